>>> rtl/rcfs_pkg.sv
// Shared types, constants and codes for the receiver channel failsafe hold block.
package rcfs_pkg;

  // Channel table geometry and special channels.
  localparam int CHANNELS         = 16;
  localparam int CONTROL_CHANNELS = 5;
  localparam int THROTTLE_INDEX   = 4;
  localparam int CHAN_W           = 4;

  // Field widths.
  localparam int PULSE_W = 16;
  localparam int TIME_W  = 32;
  localparam int REG_W   = 16;
  localparam int ADDR_W  = 3;

  // Stream word widths.
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  // Action codes carried in the input tuser.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // Failsafe mode codes.
  localparam logic [1:0] MODE_AUTO    = 2'd0;
  localparam logic [1:0] MODE_HOLD    = 2'd1;
  localparam logic [1:0] MODE_SET     = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  // Configuration register indexes.
  localparam logic [ADDR_W-1:0] REG_VALID_MIN  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_VALID_MAX  = 3'd1;
  localparam logic [ADDR_W-1:0] REG_CENTER     = 3'd2;
  localparam logic [ADDR_W-1:0] REG_THR_FLOOR  = 3'd3;
  localparam logic [ADDR_W-1:0] REG_HOLD_MS    = 3'd4;
  localparam logic [ADDR_W-1:0] REG_CLAMP_LOW  = 3'd5;
  localparam logic [ADDR_W-1:0] REG_CLAMP_HIGH = 3'd6;

  // Reset values of the registers.
  localparam logic [REG_W-1:0] RST_VALID_MIN  = 16'd885;
  localparam logic [REG_W-1:0] RST_VALID_MAX  = 16'd2115;
  localparam logic [REG_W-1:0] RST_CENTER     = 16'd1500;
  localparam logic [REG_W-1:0] RST_THR_FLOOR  = 16'd1000;
  localparam logic [REG_W-1:0] RST_HOLD_MS    = 16'd300;
  localparam logic [REG_W-1:0] RST_CLAMP_LOW  = 16'd750;
  localparam logic [REG_W-1:0] RST_CLAMP_HIGH = 16'd2250;

  // Auto throttle failsafe sits this far below the throttle floor.
  localparam logic [REG_W-1:0] AUTO_THR_DROP = 16'd50;

  // Configuration register set.
  typedef struct packed {
    logic [REG_W-1:0] valid_min;
    logic [REG_W-1:0] valid_max;
    logic [REG_W-1:0] center_value;
    logic [REG_W-1:0] throttle_floor;
    logic [REG_W-1:0] hold_time_ms;
    logic [REG_W-1:0] clamp_low;
    logic [REG_W-1:0] clamp_high;
  } cfg_t;

  // One input word after unpacking.
  typedef struct packed {
    logic               action;
    logic [CHAN_W-1:0]  channel;
    logic [PULSE_W-1:0] pulse;
    logic [TIME_W-1:0]  now_ms;
    logic               link_up;
    logic               force_switch;
    logic               frame_end;
    logic [1:0]         entry_mode;
    logic [PULSE_W-1:0] entry_value;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [CHAN_W-1:0]  out_channel;
    logic [PULSE_W-1:0] value;
    logic               held;
    logic               substituted;
    logic               flight_valid;
    logic               last;
  } res_t;

endpackage

>>> rtl/rcfs_cfg_regs.sv
// Configuration register file with a plain write port.
module rcfs_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rcfs_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [rcfs_pkg::REG_W-1:0]  cfg_wdata,
  output rcfs_pkg::cfg_t             cfg
);
  import rcfs_pkg::*;

  cfg_t cfg_r;

  // Register writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.valid_min      <= RST_VALID_MIN;
      cfg_r.valid_max      <= RST_VALID_MAX;
      cfg_r.center_value   <= RST_CENTER;
      cfg_r.throttle_floor <= RST_THR_FLOOR;
      cfg_r.hold_time_ms   <= RST_HOLD_MS;
      cfg_r.clamp_low      <= RST_CLAMP_LOW;
      cfg_r.clamp_high     <= RST_CLAMP_HIGH;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_VALID_MIN:  cfg_r.valid_min      <= cfg_wdata;
        REG_VALID_MAX:  cfg_r.valid_max      <= cfg_wdata;
        REG_CENTER:     cfg_r.center_value   <= cfg_wdata;
        REG_THR_FLOOR:  cfg_r.throttle_floor <= cfg_wdata;
        REG_HOLD_MS:    cfg_r.hold_time_ms   <= cfg_wdata;
        REG_CLAMP_LOW:  cfg_r.clamp_low      <= cfg_wdata;
        REG_CLAMP_HIGH: cfg_r.clamp_high     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/rcfs_in_stage.sv
// Input register stage: unpacks and holds one accepted word.
module rcfs_in_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rcfs_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  input  logic                           advance,
  output logic                           item_valid,
  output rcfs_pkg::item_t                item
);
  import rcfs_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  item_t item_nxt;
  logic  take;

  // The stage takes a word when empty or when its word moves on.
  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  // Unpack the stream word into fields.
  always_comb begin
    item_nxt.action       = in_tuser;
    item_nxt.channel      = in_tdata[3:0];
    item_nxt.pulse        = in_tdata[19:4];
    item_nxt.now_ms       = in_tdata[51:20];
    item_nxt.link_up      = in_tdata[52];
    item_nxt.force_switch = in_tdata[53];
    item_nxt.entry_mode   = in_tdata[55:54];
    item_nxt.entry_value  = in_tdata[71:56];
    item_nxt.frame_end    = in_tlast;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  // Stage valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload holds while the stage is stalled.
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> rtl/rcfs_core.sv
// Per-channel state tables and the hold, substitute and clamp logic.
module rcfs_core (
  input  logic            clk,
  input  logic            rst_n,
  input  rcfs_pkg::cfg_t  cfg,
  input  logic            fire,
  input  rcfs_pkg::item_t item,
  output logic            res_valid,
  output rcfs_pkg::res_t  res
);
  import rcfs_pkg::*;

  logic [PULSE_W-1:0] last_value_r [CHANNELS];
  logic [TIME_W-1:0]  deadline_r   [CHANNELS];
  logic [1:0]         fail_mode_r  [CHANNELS];
  logic [PULSE_W-1:0] fail_value_r [CHANNELS];
  logic               acc_r;
  logic               acc_nxt;

  logic               in_range;
  logic               is_sample;
  logic               is_load;
  logic               is_ctrl;
  logic               chan_ok;
  logic [TIME_W-1:0]  since_deadline;
  logic               running;
  logic [PULSE_W-1:0] last_rd;
  logic [PULSE_W-1:0] thr_auto;
  logic [PULSE_W-1:0] fallback;
  logic [PULSE_W-1:0] raw;
  logic [PULSE_W-1:0] clamped;
  logic               held;
  logic               subst;
  logic               acc_run;

  assign in_range  = int'(item.channel) < CHANNELS;
  assign is_sample = fire && in_range && (item.action == ACT_SAMPLE);
  assign is_load   = fire && in_range && (item.action == ACT_LOAD);
  assign is_ctrl   = item.channel < CHAN_W'(CONTROL_CHANNELS);
  assign last_rd   = last_value_r[item.channel];

  // A channel is good with the link up, the pulse in window and no forced failsafe on a control channel.
  assign chan_ok = item.link_up && (item.pulse >= cfg.valid_min) &&
                   (item.pulse <= cfg.valid_max) && !(item.force_switch && is_ctrl);

  // Hold time still runs while now minus deadline is negative.
  assign since_deadline = item.now_ms - deadline_r[item.channel];
  assign running        = since_deadline[TIME_W-1];

  // Auto throttle failsafe saturates at zero.
  assign thr_auto = (cfg.throttle_floor > AUTO_THR_DROP) ?
                    (cfg.throttle_floor - AUTO_THR_DROP) : '0;

  // Failsafe value chosen by the channel's mode.
  always_comb begin
    fallback = last_rd;
    case (fail_mode_r[item.channel])
      MODE_SET: fallback = fail_value_r[item.channel];
      MODE_AUTO: begin
        if (item.channel == CHAN_W'(THROTTLE_INDEX)) begin
          fallback = thr_auto;
        end else if (is_ctrl) begin
          fallback = cfg.center_value;
        end
      end
      MODE_HOLD, MODE_INVALID: fallback = last_rd;
      default: fallback = last_rd;
    endcase
  end

  // Pick live, held or substituted value.
  always_comb begin
    held  = 1'b0;
    subst = 1'b0;
    if (chan_ok) begin
      raw = item.pulse;
    end else if (running) begin
      raw  = last_rd;
      held = 1'b1;
    end else begin
      raw   = fallback;
      subst = 1'b1;
    end
  end

  // When the limits cross, a value below the lower limit gets it and any other gets the upper limit.
  always_comb begin
    if (raw < cfg.clamp_low) begin
      clamped = cfg.clamp_low;
    end else if (raw > cfg.clamp_high) begin
      clamped = cfg.clamp_high;
    end else begin
      clamped = raw;
    end
  end

  // Frame-wide flight-valid accumulation.
  assign acc_run = acc_r && item.link_up && !item.force_switch && !(subst && is_ctrl);

  always_comb begin
    acc_nxt = acc_r;
    if (is_sample) begin
      acc_nxt = item.frame_end ? 1'b1 : acc_run;
    end
  end

  // Table and accumulator updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_value_r[i] <= RST_CENTER;
        deadline_r[i]   <= '0;
        fail_mode_r[i]  <= MODE_HOLD;
        fail_value_r[i] <= RST_CENTER;
      end
      acc_r <= 1'b1;
    end else begin
      acc_r <= acc_nxt;
      if (is_load) begin
        fail_mode_r[item.channel]  <= item.entry_mode;
        fail_value_r[item.channel] <= item.entry_value;
      end
      if (is_sample) begin
        last_value_r[item.channel] <= clamped;
        if (chan_ok) begin
          deadline_r[item.channel] <= item.now_ms + TIME_W'(cfg.hold_time_ms);
        end
      end
    end
  end

  // Result word for the output register.
  assign res_valid        = is_sample;
  assign res.out_channel  = item.channel;
  assign res.value        = clamped;
  assign res.held         = held;
  assign res.substituted  = subst;
  assign res.flight_valid = item.frame_end && acc_run;
  assign res.last         = item.frame_end;

endmodule

>>> rtl/rcfs_out_stage.sv
// Output register: holds one result word until the sink takes it.
module rcfs_out_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  rcfs_pkg::res_t                  res,
  output logic                            advance,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rcfs_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [rcfs_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                            out_tlast
);
  import rcfs_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // The register is free when empty or being drained this cycle.
  assign advance = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      res_r <= res;
    end
  end

  // Pack the result word.
  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, res_r.flight_valid, res_r.value, res_r.out_channel};
  assign out_tuser  = {res_r.substituted, res_r.held};
  assign out_tlast  = res_r.last;

endmodule

>>> rtl/rc_channel_failsafe_hold.sv
// Top level of the receiver channel failsafe hold block.
// One word per cycle unless the output side stalls: a word enters the input
// register and, once the output register is free, reads and updates its
// channel's tables and lands in the output register, which offers a sample's
// result on the output. The input register takes a new word as the last one
// moves on. The per-channel tables are flip-flops read and written at the
// word's channel in the same cycle. Load words (tuser high) and words for
// channels outside the table produce no result.
module rc_channel_failsafe_hold (
  input  logic                            clk,
  input  logic                            rst_n,
  // tdata: channel[3:0], pulse[19:4], now_ms[51:20], link_up[52],
  // force_switch[53], entry_mode[55:54], entry_value[71:56]
  input  logic [rcfs_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,  // action
  input  logic                            in_tlast,  // frame_end
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: out_channel[3:0], value[19:4], flight_valid[20], zero fill[23:21]
  output logic [rcfs_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [rcfs_pkg::OUT_USER_W-1:0] out_tuser,  // held[0], substituted[1]
  output logic                            out_tlast,  // last
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [rcfs_pkg::ADDR_W-1:0]     cfg_addr,
  input  logic [rcfs_pkg::REG_W-1:0]      cfg_wdata
);
  import rcfs_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res;
  logic  item_valid;
  logic  advance;
  logic  fire;
  logic  res_valid;

  // A held word moves into the core when the output register is free.
  assign fire = item_valid && advance;

  rcfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rcfs_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rcfs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  rcfs_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> test/rc_channel_failsafe_hold_tb.sv
// Self-checking stream testbench for the receiver channel failsafe hold block.
`timescale 1ns / 100ps

module rc_channel_failsafe_hold_tb;
  import rcfs_pkg::*;

  // Cycles with no word moving on either side before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Load words give no result, so allow the pipeline to empty before a write.
  localparam int DRAIN_CYCLES = 4;
  localparam int END_CYCLES   = 8;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  in_tlast;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_we;
  logic [ADDR_W-1:0]     cfg_addr;
  logic [REG_W-1:0]      cfg_wdata;

  rc_channel_failsafe_hold i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow copy of the block's registers and per-channel tables.
  cfg_t               regs_now;
  logic [PULSE_W-1:0] last_val    [CHANNELS];
  logic [TIME_W-1:0]  deadline_ms [CHANNELS];
  logic [1:0]         fs_mode     [CHANNELS];
  logic [PULSE_W-1:0] fs_val      [CHANNELS];
  logic               frame_ok;
  res_t               channel_results_q [$];

  // Run control shared by the stimulus, the receiver pacing and the checker.
  logic [TIME_W-1:0] clock_ms = '0;
  int                words_in = 0;
  int                mismatches = 0;
  int                idle_cycles = 0;
  int                hold_req = 0;
  logic              src_gaps = 1'b1;
  logic              sink_stalls = 1'b1;

  // Value an expired channel falls back to, by its failsafe mode.
  function automatic logic [PULSE_W-1:0] substitute_value(int ch);
    logic [PULSE_W-1:0] v;
    v = last_val[ch];
    if (fs_mode[ch] == MODE_SET) begin
      v = fs_val[ch];
    end else if (fs_mode[ch] == MODE_AUTO) begin
      if (ch == THROTTLE_INDEX) begin
        v = (regs_now.throttle_floor > AUTO_THR_DROP) ?
            regs_now.throttle_floor - AUTO_THR_DROP : '0;
      end else if (ch < CONTROL_CHANNELS) begin
        v = regs_now.center_value;
      end
    end
    return v;
  endfunction

  // Update the shadow state for one accepted word and queue its result.
  function automatic void failsafe_step(item_t w);
    int                 ch;
    logic               ctrl;
    logic [PULSE_W-1:0] v;
    logic [TIME_W-1:0]  since;
    res_t               r;
    ch = int'(w.channel);
    if (ch >= CHANNELS) return;
    if (w.action == ACT_LOAD) begin
      fs_mode[ch] = w.entry_mode;
      fs_val[ch]  = w.entry_value;
      return;
    end
    ctrl = (ch < CONTROL_CHANNELS);
    r = '0;
    if (!w.link_up || w.force_switch) frame_ok = 1'b0;

    if (w.link_up && w.pulse >= regs_now.valid_min && w.pulse <= regs_now.valid_max &&
        !(w.force_switch && ctrl)) begin
      v = w.pulse;
      deadline_ms[ch] = w.now_ms + TIME_W'(regs_now.hold_time_ms);
    end else begin
      // Still holding while now - deadline is negative as a signed number.
      since = w.now_ms - deadline_ms[ch];
      if (since[TIME_W-1]) begin
        v = last_val[ch];
        r.held = 1'b1;
      end else begin
        v = substitute_value(ch);
        r.substituted = 1'b1;
        if (ctrl) frame_ok = 1'b0;
      end
    end

    // When the limits are crossed, a value below the low limit gets it and any other gets the high limit.
    if (v < regs_now.clamp_low) begin
      v = regs_now.clamp_low;
    end else if (v > regs_now.clamp_high) begin
      v = regs_now.clamp_high;
    end
    last_val[ch] = v;

    if (w.frame_end) begin
      r.flight_valid = frame_ok;
      frame_ok = 1'b1;
    end
    r.out_channel = w.channel;
    r.value       = v;
    r.last        = w.frame_end;
    channel_results_q.push_back(r);
  endfunction

  function automatic item_t make_sample(int ch, logic lnk, logic sw, logic fend,
                                        logic [PULSE_W-1:0] p);
    item_t w;
    w.action       = ACT_SAMPLE;
    w.channel      = CHAN_W'(ch);
    w.pulse        = p;
    w.now_ms       = clock_ms;
    w.link_up      = lnk;
    w.force_switch = sw;
    w.frame_end    = fend;
    w.entry_mode   = 2'($urandom);
    w.entry_value  = PULSE_W'($urandom);
    return w;
  endfunction

  // Load words carry random values in the fields that the block ignores.
  function automatic item_t make_load(int ch, logic [1:0] mode, logic [PULSE_W-1:0] value);
    item_t w;
    w.action       = ACT_LOAD;
    w.channel      = CHAN_W'(ch);
    w.pulse        = PULSE_W'($urandom);
    w.now_ms       = $urandom;
    w.link_up      = 1'($urandom);
    w.force_switch = 1'($urandom);
    w.frame_end    = 1'($urandom);
    w.entry_mode   = mode;
    w.entry_value  = value;
    return w;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Offer one word, with an occasional gap in front, and wait for it to be taken.
  task automatic send_word(item_t w);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.action;
    in_tlast  <= w.frame_end;
    in_tdata  <= {w.entry_value, w.entry_mode, w.force_switch, w.link_up,
                  w.now_ms, w.pulse, w.channel};
    do @(posedge clk); while (in_tready !== 1'b1);
    failsafe_step(w);
    words_in++;
  endtask

  // Stop offering and wait until every expected word has come out.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (channel_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all seven registers; only called while the block is idle.
  task automatic program_regs(input logic [REG_W-1:0] vmin, vmax, ctr, flr, hold, lo, hi);
    logic [REG_W-1:0]  vals  [7];
    logic [ADDR_W-1:0] addrs [7];
    vals  = '{vmin, vmax, ctr, flr, hold, lo, hi};
    addrs = '{REG_VALID_MIN, REG_VALID_MAX, REG_CENTER, REG_THR_FLOOR,
              REG_HOLD_MS, REG_CLAMP_LOW, REG_CLAMP_HIGH};
    for (int k = 0; k < $size(addrs); k++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= addrs[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    regs_now.valid_min      = vmin;
    regs_now.valid_max      = vmax;
    regs_now.center_value   = ctr;
    regs_now.throttle_floor = flr;
    regs_now.hold_time_ms   = hold;
    regs_now.clamp_low      = lo;
    regs_now.clamp_high     = hi;
  endtask

  // Fill every channel's failsafe entry with a random mode and value.
  task automatic load_all_entries();
    logic [PULSE_W-1:0] v;
    for (int c = 0; c < CHANNELS; c++) begin
      v = ($urandom_range(0, 3) == 0) ? PULSE_W'($urandom) : PULSE_W'($urandom_range(800, 2200));
      send_word(make_load(c, 2'($urandom), v));
    end
  endtask

  // Receiver frames: mostly in-order channels ending with tlast, with link
  // outages, switch activity, stray load words and some truncated frames.
  task automatic run_frames(int n);
    int                 stop_at;
    int                 nch;
    int                 outage;
    int                 ch;
    logic               lnk;
    logic               sw;
    logic               fend;
    logic [PULSE_W-1:0] p;
    stop_at = words_in + n;
    outage = 0;
    while (words_in < stop_at) begin
      nch = $urandom_range(4, CHANNELS);
      if (outage > 0) begin
        outage--;
      end else if ($urandom_range(0, 9) == 0) begin
        outage = $urandom_range(1, 25);
      end
      sw = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < nch; k++) begin
        if ($urandom_range(0, 14) == 0) begin
          send_word(make_load($urandom_range(0, CHANNELS - 1), 2'($urandom), PULSE_W'($urandom)));
        end
        ch   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, CHANNELS - 1) : k;
        lnk  = (outage == 0) && ($urandom_range(0, 29) != 0);
        fend = (k == nch - 1) && ($urandom_range(0, 19) != 0);
        p    = ($urandom_range(0, 4) == 0) ? PULSE_W'($urandom) :
               PULSE_W'($urandom_range(regs_now.valid_min, regs_now.valid_max));
        send_word(make_sample(ch, lnk, sw, fend, p));
      end
      // Frame period, with rare long gaps and jumps anywhere on the clock.
      if ($urandom_range(0, 19) == 0) begin
        clock_ms += $urandom_range(300, 140000);
      end else if ($urandom_range(0, 39) == 0) begin
        clock_ms = $urandom;
      end else begin
        clock_ms += $urandom_range(5, 40);
      end
    end
  endtask

  // Window edges, link loss, the switch on control and aux channels, and
  // the frame-wide flag, all at reset settings.
  task automatic test_validity_window();
    clock_ms = 32'h0001_0000;
    send_word(make_sample(0, 1'b1, 1'b0, 1'b0, RST_VALID_MIN));
    send_word(make_sample(1, 1'b1, 1'b0, 1'b0, RST_VALID_MAX));
    send_word(make_sample(2, 1'b1, 1'b0, 1'b0, RST_VALID_MIN - 16'd1));
    send_word(make_sample(3, 1'b1, 1'b0, 1'b0, RST_VALID_MAX + 16'd1));
    send_word(make_sample(6, 1'b1, 1'b1, 1'b0, 16'd1200));
    send_word(make_sample(15, 1'b1, 1'b0, 1'b1, 16'hFFFF));
    // Inside the hold time: bad pulse, forced control channel, link down.
    clock_ms += 20;
    send_word(make_sample(0, 1'b1, 1'b0, 1'b0, 16'd0));
    send_word(make_sample(1, 1'b1, 1'b1, 1'b0, 16'd1600));
    send_word(make_sample(6, 1'b0, 1'b0, 1'b0, 16'd1600));
    send_word(make_sample(15, 1'b1, 1'b0, 1'b1, 16'd1700));
    // Exactly at the deadline the hold time is over.
    clock_ms += 280;
    send_word(make_sample(0, 1'b1, 1'b0, 1'b1, 16'd5));
    settle_block();
  endtask

  // Entries in auto, set and invalid mode, then every loaded channel runs out.
  task automatic test_failsafe_modes();
    int chans [5];
    chans = '{THROTTLE_INDEX, 1, 2, 3, 9};
    send_word(make_load(THROTTLE_INDEX, MODE_AUTO, 16'd1234));
    send_word(make_load(1, MODE_AUTO, 16'd0));
    send_word(make_load(2, MODE_SET, 16'hFFFF));
    send_word(make_load(3, MODE_INVALID, 16'd1800));
    send_word(make_load(9, MODE_AUTO, 16'd1900));
    clock_ms += 32'd10000;
    foreach (chans[k]) begin
      send_word(make_sample(chans[k], 1'b0, 1'b0, k == $size(chans) - 1, 16'd1500));
    end
    settle_block();
  endtask

  // A deadline that wraps past zero, and the half-range edge of the compare.
  task automatic test_deadline_wrap();
    logic [TIME_W-1:0] due;
    due = 32'hFFFF_FF00 + TIME_W'(RST_HOLD_MS);
    clock_ms = 32'hFFFF_FF00;
    send_word(make_sample(7, 1'b1, 1'b0, 1'b0, 16'd1111));
    clock_ms = 32'hFFFF_FFC8;
    send_word(make_sample(7, 1'b0, 1'b0, 1'b0, 16'd1111));
    clock_ms = due;
    send_word(make_sample(7, 1'b0, 1'b0, 1'b0, 16'd1111));
    clock_ms = due + 32'h8000_0000;
    send_word(make_sample(7, 1'b1, 1'b0, 1'b0, 16'd0));
    clock_ms = due + 32'h7FFF_FFFF;
    send_word(make_sample(7, 1'b1, 1'b0, 1'b1, 16'd0));
    settle_block();
  endtask

  // Random frames under several register settings, extremes among them.
  task automatic test_random_traffic();
    load_all_entries();
    run_frames(70);
    settle_block();

    // Everything passes the window, zero hold time, throttle auto drops to zero.
    program_regs(16'd0, 16'hFFFF, 16'd0, 16'd50, 16'd0, 16'd0, 16'hFFFF);
    run_frames(80);
    settle_block();

    // Longest hold, throttle floor below the drop, crossed clamp limits.
    program_regs(16'd1000, 16'd2000, 16'hFFFF, 16'd20, 16'hFFFF, 16'd2000, 16'd1000);
    send_word(make_load(THROTTLE_INDEX, MODE_AUTO, 16'd1500));
    run_frames(80);
    settle_block();

    // Crossed window: no pulse is valid.
    program_regs(RST_VALID_MAX, RST_VALID_MIN, REG_W'($urandom),
                 REG_W'($urandom_range(0, 100)), REG_W'($urandom_range(0, 600)),
                 REG_W'($urandom_range(0, 1000)), REG_W'($urandom_range(1500, 65535)));
    load_all_entries();
    run_frames(80);
    settle_block();
  endtask

  // The receiver holds off for a long stretch while words keep coming,
  // then the sender waits for the block to empty before going on.
  task automatic test_backpressure();
    program_regs(RST_VALID_MIN, RST_VALID_MAX, RST_CENTER, RST_THR_FLOOR,
                 RST_HOLD_MS, RST_CLAMP_LOW, RST_CLAMP_HIGH);
    hold_req = 120;
    run_frames(50);
    settle_block();
    run_frames(30);
    settle_block();
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    program_regs(REG_W'($urandom_range(0, 1200)), REG_W'($urandom_range(1800, 65535)),
                 REG_W'($urandom), REG_W'($urandom_range(0, 2000)),
                 REG_W'($urandom_range(0, 400)), REG_W'($urandom_range(0, 900)),
                 REG_W'($urandom_range(2000, 65535)));
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    run_frames(80);
  endtask

  // Receiver pacing: runs of ready and stall, plus any requested hold-off.
  initial begin : sink_pace
    int   run;
    logic rdy;
    run = 0;
    rdy = 1'b1;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        rdy = 1'b0;
        run = hold_req;
        hold_req = 0;
      end else if (run <= 0) begin
        rdy = !(sink_stalls && $urandom_range(0, 3) == 0);
        run = rdy ? $urandom_range(1, 24) : $urandom_range(1, 16);
      end
      run--;
      out_tready <= rdy;
    end
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (channel_results_q.size() == 0) begin
        flag_mismatch("unexpected word, channel", 32'(out_tdata[CHAN_W-1:0]), 32'd0);
      end else begin
        want = channel_results_q.pop_front();
        if (out_tdata[CHAN_W-1:0] != want.out_channel)
          flag_mismatch("channel", 32'(out_tdata[CHAN_W-1:0]), 32'(want.out_channel));
        if (out_tdata[CHAN_W +: PULSE_W] != want.value)
          flag_mismatch("value", 32'(out_tdata[CHAN_W +: PULSE_W]), 32'(want.value));
        if (out_tdata[CHAN_W + PULSE_W] != want.flight_valid)
          flag_mismatch("flight_valid", 32'(out_tdata[CHAN_W + PULSE_W]),
                        32'(want.flight_valid));
        if (out_tuser[0] != want.held)
          flag_mismatch("held", 32'(out_tuser[0]), 32'(want.held));
        if (out_tuser[1] != want.substituted)
          flag_mismatch("substituted", 32'(out_tuser[1]), 32'(want.substituted));
        if (out_tlast != want.last)
          flag_mismatch("last", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  // Hang detection: too long with no word moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("rc_channel_failsafe_hold_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;

    // Shadow state at reset.
    regs_now.valid_min      = RST_VALID_MIN;
    regs_now.valid_max      = RST_VALID_MAX;
    regs_now.center_value   = RST_CENTER;
    regs_now.throttle_floor = RST_THR_FLOOR;
    regs_now.hold_time_ms   = RST_HOLD_MS;
    regs_now.clamp_low      = RST_CLAMP_LOW;
    regs_now.clamp_high     = RST_CLAMP_HIGH;
    for (int c = 0; c < CHANNELS; c++) begin
      last_val[c]    = RST_CENTER;
      deadline_ms[c] = '0;
      fs_mode[c]     = MODE_HOLD;
      fs_val[c]      = RST_CENTER;
    end
    frame_ok = 1'b1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_validity_window();
    test_failsafe_modes();
    test_deadline_wrap();
    test_random_traffic();
    test_backpressure();
    test_full_rate();

    settle_block();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && channel_results_q.size() == 0) begin
      $display("rc_channel_failsafe_hold_tb: clean");
    end else begin
      $display("rc_channel_failsafe_hold_tb: errors");
    end
    $finish;
  end

endmodule
